// ----- rtl/sps_pkg.sv -----
//------------------------------------------------------------------------------
// sps_pkg
// shared types and constants of the segmented prime sieve
//------------------------------------------------------------------------------
`default_nettype none
package sps_pkg;
    localparam int unsigned CUTOFF_W   = 32;
    localparam int unsigned SEGSIZE_W  = 13;
    localparam int unsigned PRIME_W    = 17;
    localparam int unsigned INDEX_W    = 32;
    localparam int unsigned BASE_W     = 33;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SIEVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGSIZE = 1'd1;
endpackage
`default_nettype wire

// ----- rtl/sps_req_if.sv -----
//------------------------------------------------------------------------------
// sps_req_if
// request channel: operation, base prime, segment index
//------------------------------------------------------------------------------
`default_nettype none
interface sps_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [sps_pkg::PRIME_W-1:0]   base_prime;
    logic [sps_pkg::INDEX_W-1:0]   segment_index;
    modport source (output valid, func, base_prime, segment_index, input ready);
    modport sink   (input valid, func, base_prime, segment_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/sps_rsp_if.sv -----
//------------------------------------------------------------------------------
// sps_rsp_if
// result channel: one or more prime mask words per request
//------------------------------------------------------------------------------
`default_nettype none
interface sps_rsp_if #(parameter int MASK_WIDTH = 64);
    logic                           valid;
    logic                           ready;
    logic [sps_pkg::BASE_W-1:0]     word_base;
    logic [MASK_WIDTH-1:0]          prime_mask;
    logic [$clog2(MASK_WIDTH+1)-1:0] primes_in_word;
    logic [sps_pkg::STATUS_W-1:0]   status;
    logic                           last_word;
    modport source (output valid, word_base, prime_mask, primes_in_word, status,
                    last_word, input ready);
    modport sink   (input valid, word_base, prime_mask, primes_in_word, status,
                    last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/sps_divider.sv -----
//------------------------------------------------------------------------------
// sps_divider
// radix-2 restoring divider, one quotient bit per cycle
//------------------------------------------------------------------------------
`default_nettype none
module sps_divider #(
    parameter int NW = 34,
    parameter int DW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(NW+1);
    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [DW:0]   w_sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[DW-1:0], r_quo[NW-1]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DW-1:0];
endmodule
`default_nettype wire

// ----- rtl/segmented_prime_sieve.sv -----
//------------------------------------------------------------------------------
// segmented_prime_sieve
// segmented sieve of eratosthenes over a base prime table and bitmap memory
//------------------------------------------------------------------------------
// channel   dir  handshake      payload
// req       in   valid/ready    func, base_prime, segment_index
// rsp       out  valid/ready    word_base, prime_mask, primes_in_word, status,
//                               last_word
// cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data
//
// a load (or a sieve with cutoff below two) answers with a single status word.
// a sieve runs the range check on the 34-step divider and answers an
// out-of-range index with a single status word; else it fills the bitmap one word
// per cycle, reads each table entry, and for each entry that sieves runs the
// divider, then reads and writes back each cleared multiple; then sends each word.
// synchronous active-low reset empties the table; no clearing pass.
// a stalled result holds the sequencer; one request at a time.
//------------------------------------------------------------------------------
`default_nettype none
module segmented_prime_sieve #(
    parameter int SEGMENT_MAX      = 4096,
    parameter int BASE_TABLE_DEPTH = 8192,
    parameter int MASK_WIDTH       = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sps_pkg::CUTOFF_W-1:0]    i_cfg_data,
    sps_req_if.sink                              req,
    sps_rsp_if.source                            rsp
);
    localparam int WORDS  = (SEGMENT_MAX + MASK_WIDTH - 1) / MASK_WIDTH;
    localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_A  = $clog2(MASK_WIDTH);
    localparam int TA     = $clog2(BASE_TABLE_DEPTH);
    localparam int CNT_W  = $clog2(BASE_TABLE_DEPTH + 1);
    localparam int OFF_W  = $clog2(SEGMENT_MAX + 1);
    localparam int PC_W   = $clog2(MASK_WIDTH + 1);
    localparam int NW     = 34;
    localparam int PW     = sps_pkg::PRIME_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RDIV  = 13'b0000000000010,
        S_RCHK  = 13'b0000000000100,
        S_FILL  = 13'b0000000001000,
        S_TRD   = 13'b0000000010000,
        S_TCHK  = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_MRD   = 13'b0000010000000,
        S_MWR   = 13'b0000100000000,
        S_ORD   = 13'b0001000000000,
        S_OUT   = 13'b0010000000000,
        S_ONE   = 13'b0100000000000,
        S_SQ    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [sps_pkg::CUTOFF_W-1:0]  r_cutoff;
    logic [sps_pkg::SEGSIZE_W-1:0] r_segsize;
    logic [CNT_W-1:0]              r_count;

    logic [PW-1:0]         table_mem [BASE_TABLE_DEPTH];
    logic [MASK_WIDTH-1:0] bmap_mem  [WORDS];
    logic [PW-1:0]         r_tdata;
    logic [MASK_WIDTH-1:0] r_bdata;

    logic [OFF_W-1:0]  w_size;
    logic [33:0]       r_low, r_high;
    logic [OFF_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_t;
    logic [WA:0]       r_w;
    logic [WA:0]       w_words;
    logic [WA-1:0]     w_baddr;
    logic [PW-1:0]     r_p;
    logic [33:0]       r_psq;
    logic [33:0]       r_m;
    logic [OFF_W-1:0]  w_off;
    logic [sps_pkg::STATUS_W-1:0] r_st;

    logic              r_rvalid;
    logic [sps_pkg::BASE_W-1:0] r_obase;
    logic [MASK_WIDTH-1:0] r_omask;
    logic [sps_pkg::STATUS_W-1:0] r_ostat;
    logic              r_olast;

    logic              w_dstart, w_ddone;
    logic [NW-1:0]     w_dnum, w_dquo;
    logic [PW-1:0]     w_dden, w_drem;
    logic [33:0]       w_first;
    logic              w_accept, w_out_fire;
    logic [MASK_WIDTH-1:0] w_fillmask;

    // clamp segment size
    always_comb begin
        if (r_segsize == '0) w_size = OFF_W'(1);
        else if (32'(r_segsize) > 32'(SEGMENT_MAX)) w_size = OFF_W'(SEGMENT_MAX);
        else w_size = OFF_W'(r_segsize);
    end

    assign w_words  = (WA+1)'((32'(r_n) + MASK_WIDTH - 1) >> BIT_A);
    assign w_accept = req.valid && req.ready;
    assign w_out_fire = rsp.valid && rsp.ready;
    assign req.ready = (r_state == S_IDLE) && !r_rvalid;
    assign w_off = OFF_W'(r_m - r_low);
    // marking reads the word of the current multiple
    assign w_baddr = (r_state == S_MRD) ? WA'(w_off >> BIT_A) : r_w[WA-1:0];

    // divider shared by range check and first-multiple search
    assign w_dstart = (w_accept && req.func == sps_pkg::FUNC_SIEVE && r_cutoff >= 32'd2)
                      || (r_state == S_TCHK && r_tdata >= PW'(2) &&
                          r_psq < r_high);
    always_comb begin
        if (r_state == S_IDLE) begin
            w_dnum = NW'(r_cutoff - 32'd2);
            w_dden = PW'(w_size);
        end else begin
            w_dnum = NW'(r_low + 34'(r_tdata) - 34'd1);
            w_dden = r_tdata;
        end
    end

    sps_divider #(.NW(NW), .DW(PW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_done (w_ddone),
        .o_quo  (w_dquo),
        .o_rem  (w_drem)
    );

    logic [50:0] w_prod;
    assign w_prod  = 51'(w_dquo) * 51'(r_p);
    assign w_first = (34'(w_prod) < r_psq) ? r_psq : 34'(w_prod);

    always_comb begin
        w_fillmask = '0;
        for (int b = 0; b < MASK_WIDTH; b++)
            if (32'(r_w) * MASK_WIDTH + b < 32'(r_n)) w_fillmask[b] = 1'b1;
    end

    logic [31:0] r_idx;
    logic [49:0] w_lowprod;
    assign w_lowprod = 50'(r_idx) * 50'(w_size);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (req.func == sps_pkg::FUNC_LOAD) n_state = S_ONE;
                    else if (r_cutoff < 32'd2) n_state = S_ONE;
                    else n_state = S_RDIV;
                end
            end
            S_RDIV: if (w_ddone) n_state = S_RCHK;
            S_RCHK: n_state = (34'(r_idx) >= 34'(w_dquo) + 34'd1) ? S_ONE : S_FILL;
            S_FILL: if (r_w + 1'b1 >= w_words) n_state = S_TRD;
            S_TRD:  n_state = (r_t >= r_count) ? S_ORD : S_SQ;
            S_SQ:   n_state = S_TCHK;
            S_TCHK: n_state = (r_tdata >= PW'(2) && r_psq < r_high) ? S_DIV : S_TRD;
            S_DIV:  if (w_ddone) n_state = S_MRD;
            S_MRD:  n_state = (r_m < r_high) ? S_MWR : S_TRD;
            S_MWR:  n_state = S_MRD;
            S_ORD:  n_state = S_OUT;
            S_OUT:  if (!r_rvalid || w_out_fire)
                        n_state = (r_w + 1'b1 >= w_words) ? S_IDLE : S_ORD;
            S_ONE:  if (!r_rvalid || w_out_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cutoff  <= 32'd65536;
            r_segsize <= 13'd4096;
            r_count   <= '0;
            r_rvalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == sps_pkg::REG_CUTOFF) r_cutoff <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == sps_pkg::REG_SEGSIZE)
                r_segsize <= i_cfg_data[sps_pkg::SEGSIZE_W-1:0];
            if (w_accept && req.func == sps_pkg::FUNC_LOAD &&
                32'(r_count) < 32'(BASE_TABLE_DEPTH))
                r_count <= r_count + 1'b1;
            if ((r_state == S_OUT || r_state == S_ONE) && (!r_rvalid || w_out_fire))
                r_rvalid <= 1'b1;
            else if (w_out_fire)
                r_rvalid <= 1'b0;
        end
    end

    // datapath and memories
    always_ff @(posedge i_clk) begin
        if (w_accept && req.func == sps_pkg::FUNC_LOAD &&
            32'(r_count) < 32'(BASE_TABLE_DEPTH))
            table_mem[r_count[TA-1:0]] <= req.base_prime;
        r_tdata <= table_mem[r_t[TA-1:0]];
        r_bdata <= bmap_mem[w_baddr];

        case (r_state)
            S_IDLE: begin
                r_idx <= req.segment_index;
                r_st  <= (req.func == sps_pkg::FUNC_LOAD)
                         ? ((32'(r_count) < 32'(BASE_TABLE_DEPTH)) ? sps_pkg::ST_OK
                                                                  : sps_pkg::ST_FULL)
                         : sps_pkg::ST_RANGE;
            end
            S_RCHK: begin
                r_low  <= 34'd2 + 34'(w_lowprod);
                r_high <= ((34'd2 + 34'(w_lowprod) + 34'(w_size)) > 34'(r_cutoff) + 34'd1)
                          ? 34'(r_cutoff) + 34'd1
                          : 34'd2 + 34'(w_lowprod) + 34'(w_size);
                r_n    <= ((34'd2 + 34'(w_lowprod) + 34'(w_size)) > 34'(r_cutoff) + 34'd1)
                          ? OFF_W'(34'(r_cutoff) + 34'd1 - 34'd2 - 34'(w_lowprod))
                          : w_size;
                r_w <= '0;
                r_t <= '0;
            end
            S_FILL: begin
                bmap_mem[r_w[WA-1:0]] <= w_fillmask;
                r_w <= (r_w + 1'b1 >= w_words) ? '0 : r_w + 1'b1;
            end
            S_TRD: ;
            S_SQ: begin
                r_p   <= r_tdata;
                r_psq <= 34'(r_tdata) * 34'(r_tdata);
                r_t   <= r_t + 1'b1;
            end
            S_DIV: if (w_ddone) r_m <= w_first;
            S_MRD: r_w <= (WA+1)'(w_off >> BIT_A);
            S_MWR: begin
                bmap_mem[r_w[WA-1:0]] <= r_bdata & ~(MASK_WIDTH'(1) << w_off[BIT_A-1:0]);
                r_m <= r_m + 34'(r_p);
            end
            S_ORD: ;
            S_OUT: if (!r_rvalid || w_out_fire) begin
                r_obase <= sps_pkg::BASE_W'(r_low + (34'(r_w) << BIT_A));
                r_omask <= r_bdata;
                r_ostat <= sps_pkg::ST_OK;
                r_olast <= (r_w + 1'b1 >= w_words);
                r_w     <= r_w + 1'b1;
            end
            S_ONE: if (!r_rvalid || w_out_fire) begin
                r_obase <= '0;
                r_omask <= '0;
                r_ostat <= r_st;
                r_olast <= 1'b1;
            end
            default: ;
        endcase
        if (r_state == S_TRD && r_t >= r_count) r_w <= '0;
    end

    logic [PC_W-1:0] w_pop;
    always_comb begin
        w_pop = '0;
        for (int b = 0; b < MASK_WIDTH; b++) w_pop = w_pop + PC_W'(r_omask[b]);
    end

    assign rsp.valid          = r_rvalid;
    assign rsp.word_base      = r_obase;
    assign rsp.prime_mask     = r_omask;
    assign rsp.primes_in_word = w_pop;
    assign rsp.status         = r_ostat;
    assign rsp.last_word      = r_olast;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(BASE_TABLE_DEPTH)) else $error("table count overflow");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && rsp.status != sps_pkg::ST_OK |-> rsp.last_word)
        else $error("error result not last");
    a_mark_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MWR |-> r_m < r_high && r_m >= r_low) else $error("mark outside segment");
endmodule
`default_nettype wire

// ----- dv/segmented_prime_sieve_tb.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// segmented_prime_sieve_tb
// drives base prime loads and segment sieve requests with random gaps on both
// channels, predicts every prime mask word and compares it with the block
//------------------------------------------------------------------------------
module segmented_prime_sieve_tb;

    localparam int SEG_MAX   = 4096;
    localparam int TAB_DEPTH = 8192;
    localparam int NO_TYPED  = -1;
    localparam int DIR_ROWS  = 16;

    typedef struct {
        logic [sps_pkg::BASE_W-1:0]   word_base;
        logic [63:0]                  prime_mask;
        logic [6:0]                   primes_in_word;
        logic [sps_pkg::STATUS_W-1:0] status;
        logic                         last_word;
    } t_mask_word;

    typedef struct {
        logic                         func;
        logic [sps_pkg::PRIME_W-1:0]  bp;
        logic [sps_pkg::INDEX_W-1:0]  idx;
        int                           typed_st;
    } t_stim;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [sps_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sps_pkg::CUTOFF_W-1:0]  i_cfg_data;

    sps_req_if req_ch ();
    sps_rsp_if #(.MASK_WIDTH(64)) rsp_ch ();

    segmented_prime_sieve dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch)
    );

    // predictor state
    logic [sps_pkg::PRIME_W-1:0]   prime_tab [TAB_DEPTH];
    int unsigned                   prime_cnt;
    logic [sps_pkg::CUTOFF_W-1:0]  cur_cutoff;
    logic [sps_pkg::SEGSIZE_W-1:0] cur_segsize;

    t_mask_word pending_words [$];
    t_stim dir_rows [DIR_ROWS];
    int unsigned errors;
    int unsigned words_seen;
    bit calm;
    bit long_hold_done;
    longint unsigned next_load;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void add_expected(input t_mask_word w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned eff_size();
        longint unsigned sz;
        sz = cur_segsize;
        if (sz == 0) sz = 1;
        if (sz > SEG_MAX) sz = SEG_MAX;
        return sz;
    endfunction

    function automatic longint unsigned segment_count();
        if (cur_cutoff < 2) return 0;
        return (longint'(cur_cutoff) - 2) / eff_size() + 1;
    endfunction

    // appends the mask words one request produces and updates the table
    function automatic void predict_request(input logic func,
                                            input logic [sps_pkg::PRIME_W-1:0] bp,
                                            input logic [sps_pkg::INDEX_W-1:0] idx);
        t_mask_word w;
        logic [63:0] bitmap [64];
        longint unsigned low, high, n, p, first, m, off, nwords;
        w.word_base = '0;
        w.prime_mask = '0;
        w.primes_in_word = '0;
        w.status = sps_pkg::ST_OK;
        w.last_word = 1'b1;
        if (func == sps_pkg::FUNC_LOAD) begin
            if (prime_cnt >= TAB_DEPTH) begin
                w.status = sps_pkg::ST_FULL;
            end else begin
                prime_tab[prime_cnt] = bp;
                prime_cnt++;
            end
            add_expected(w);
            return;
        end
        if (longint'(idx) >= segment_count()) begin
            w.status = sps_pkg::ST_RANGE;
            add_expected(w);
            return;
        end
        low = 2 + longint'(idx) * eff_size();
        high = low + eff_size();
        if (longint'(cur_cutoff) + 1 < high) high = longint'(cur_cutoff) + 1;
        n = high - low;
        for (int i = 0; i < 64; i++) bitmap[i] = '0;
        for (longint unsigned i = 0; i < n; i++) bitmap[i / 64][i % 64] = 1'b1;
        for (int unsigned t = 0; t < prime_cnt; t++) begin
            p = prime_tab[t];
            if (p < 2 || p * p >= high) continue;
            first = ((low + p - 1) / p) * p;
            if (first < p * p) first = p * p;
            for (m = first; m < high; m += p) begin
                off = m - low;
                bitmap[off / 64][off % 64] = 1'b0;
            end
        end
        nwords = (n + 63) / 64;
        for (longint unsigned i = 0; i < nwords; i++) begin
            w.word_base = sps_pkg::BASE_W'(low + i * 64);
            w.prime_mask = bitmap[i];
            w.primes_in_word = 7'($countones(bitmap[i]));
            w.status = sps_pkg::ST_OK;
            w.last_word = (i + 1 == nwords);
            add_expected(w);
        end
    endfunction

    // typed_st < 0 means the predictor supplies the expected words
    task automatic send_request(input logic func, input logic [sps_pkg::PRIME_W-1:0] bp,
                                input logic [sps_pkg::INDEX_W-1:0] idx,
                                input int typed_st = NO_TYPED);
        int unsigned g;
        int unsigned depth;
        t_mask_word w;
        g = gap_len();
        if (g != 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= func;
        req_ch.base_prime <= bp;
        req_ch.segment_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        depth = pending_words.size();
        predict_request(func, bp, idx);
        if (typed_st >= 0) begin
            while (pending_words.size() > depth) void'(pending_words.pop_back());
            w.word_base = '0;
            w.prime_mask = '0;
            w.primes_in_word = '0;
            w.status = typed_st[sps_pkg::STATUS_W-1:0];
            w.last_word = 1'b1;
            add_expected(w);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sps_pkg::CFG_IDX_W-1:0] ridx,
                             input logic [sps_pkg::CUTOFF_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ridx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (ridx == sps_pkg::REG_CUTOFF) cur_cutoff = val;
        else cur_segsize = val[sps_pkg::SEGSIZE_W-1:0];
    endtask

    function automatic bit is_prime(input longint unsigned v);
        if (v < 2) return 0;
        for (longint unsigned d = 2; d * d <= v; d++) if (v % d == 0) return 0;
        return 1;
    endfunction

    task automatic random_request();
        longint unsigned nseg;
        logic [sps_pkg::INDEX_W-1:0] idx;
        logic [sps_pkg::PRIME_W-1:0] bp;
        int unsigned r;
        r = $urandom_range(0, 99);
        bp = sps_pkg::PRIME_W'($urandom_range(0, 32'h1FFFF));
        if (r < 30) begin
            // mostly the next prime in ascending order, sometimes noise
            if ($urandom_range(0, 99) < 80 && prime_cnt < 300) begin
                next_load++;
                while (!is_prime(next_load)) next_load++;
                bp = sps_pkg::PRIME_W'(next_load);
            end
            send_request(sps_pkg::FUNC_LOAD, bp, $urandom());
        end else begin
            nseg = segment_count();
            r = $urandom_range(0, 99);
            if (nseg == 0 || r >= 85) idx = $urandom();
            else if (r < 60) idx = $urandom_range(0, 32'(nseg - 1));
            else if (r < 75) idx = 32'(nseg - 1);
            else if (nseg <= 64'hFFFF_FFFF) idx = 32'(nseg);
            else idx = $urandom();
            send_request(sps_pkg::FUNC_SIEVE, bp, idx);
        end
    endtask

    // result side: random stalls plus one long hold-off mid-run
    initial begin
        int unsigned g;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && words_seen >= 40) begin
                long_hold_done = 1;
                rsp_ch.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            g = gap_len();
            if (g != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_mask_word e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result word_base=%h status=%0d", $time,
                         rsp_ch.word_base, rsp_ch.status);
                errors++;
            end else begin
                e = pending_words.pop_front();
                if (rsp_ch.word_base !== e.word_base) begin
                    $display("%0t: word_base exp %h got %h", $time, e.word_base,
                             rsp_ch.word_base);
                    errors++;
                end
                if (rsp_ch.prime_mask !== e.prime_mask) begin
                    $display("%0t: prime_mask exp %h got %h", $time, e.prime_mask,
                             rsp_ch.prime_mask);
                    errors++;
                end
                if (rsp_ch.primes_in_word !== e.primes_in_word) begin
                    $display("%0t: primes_in_word exp %0d got %0d", $time,
                             e.primes_in_word, rsp_ch.primes_in_word);
                    errors++;
                end
                if (rsp_ch.status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.last_word !== e.last_word) begin
                    $display("%0t: last_word exp %0d got %0d", $time, e.last_word,
                             rsp_ch.last_word);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [sps_pkg::CUTOFF_W-1:0] cut_list [9];
        logic [sps_pkg::CUTOFF_W-1:0] size_list [9];
        errors = 0;
        words_seen = 0;
        calm = 0;
        long_hold_done = 0;
        prime_cnt = 0;
        next_load = 13;
        cur_cutoff = 65536;
        cur_segsize = 4096;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = sps_pkg::REG_CUTOFF;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = sps_pkg::FUNC_LOAD;
        req_ch.base_prime = '0;
        req_ch.segment_index = '0;

        // directed table at reset settings
        dir_rows[0]  = '{sps_pkg::FUNC_SIEVE, 17'h1FFFF, 32'd0, NO_TYPED}; // empty table
        dir_rows[1]  = '{sps_pkg::FUNC_LOAD, 17'd2, 32'hFFFF_FFFF, int'(sps_pkg::ST_OK)};
        dir_rows[2]  = '{sps_pkg::FUNC_LOAD, 17'd3, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[3]  = '{sps_pkg::FUNC_LOAD, 17'd5, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[4]  = '{sps_pkg::FUNC_LOAD, 17'd7, 32'd0, int'(sps_pkg::ST_OK)};
        // not a prime, skipped while sieving
        dir_rows[5]  = '{sps_pkg::FUNC_LOAD, 17'd0, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[6]  = '{sps_pkg::FUNC_LOAD, 17'd1, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[7]  = '{sps_pkg::FUNC_LOAD, 17'd13, 32'd0, int'(sps_pkg::ST_OK)};
        // out of order
        dir_rows[8]  = '{sps_pkg::FUNC_LOAD, 17'd11, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[9]  = '{sps_pkg::FUNC_LOAD, 17'd65536, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[10] = '{sps_pkg::FUNC_LOAD, 17'h1FFFF, 32'd0, int'(sps_pkg::ST_OK)};
        dir_rows[11] = '{sps_pkg::FUNC_SIEVE, 17'd0, 32'd0, NO_TYPED};
        dir_rows[12] = '{sps_pkg::FUNC_SIEVE, 17'd0, 32'd1, NO_TYPED};
        // last segment
        dir_rows[13] = '{sps_pkg::FUNC_SIEVE, 17'd0, 32'd15, NO_TYPED};
        dir_rows[14] = '{sps_pkg::FUNC_SIEVE, 17'd0, 32'd16, int'(sps_pkg::ST_RANGE)};
        dir_rows[15] = '{sps_pkg::FUNC_SIEVE, 17'd0, 32'hFFFF_FFFF,
                         int'(sps_pkg::ST_RANGE)};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_request(dir_rows[r].func, dir_rows[r].bp, dir_rows[r].idx,
                         dir_rows[r].typed_st);
        for (int unsigned v = 17; v < 60; v++) begin
            if (is_prime(v))
                send_request(sps_pkg::FUNC_LOAD, 17'(v), 32'd0, int'(sps_pkg::ST_OK));
        end
        next_load = 59;
        send_request(sps_pkg::FUNC_SIEVE, 17'd0, 32'd7);
        wait_idle();

        cut_list  = '{32'd1000, 32'd2, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5000,
                      32'd300, 32'd65536, 32'd1};
        size_list = '{32'd100, 32'd1, 32'd64, 32'd4096, 32'd0, 32'd8191,
                      32'd64, 32'd4096, 32'd7};
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(sps_pkg::REG_CUTOFF, cut_list[ph]);
            write_reg(sps_pkg::REG_SEGSIZE, size_list[ph]);
            calm = (ph == 5);
            for (int k = 0; k < 8; k++) random_request();
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/sps_pkg.sv
rtl/sps_req_if.sv
rtl/sps_rsp_if.sv
rtl/sps_divider.sv
rtl/segmented_prime_sieve.sv
dv/segmented_prime_sieve_tb.sv
